// ----- rtl/core/circular_queue_remove_by_key_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the circular queue block
// Clocked assertions with reset gating, and a plain clocked form.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_REMOVE_BY_KEY_TOP_ASSERT_SVH
`define CIRCULAR_QUEUE_REMOVE_BY_KEY_TOP_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define CQRK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CQRK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/cqrk_pkg.sv -----
// ----------------------------------------------------------------------------
// cqrk_pkg
// Types and codes shared by the circular queue block and its checker.
// ----------------------------------------------------------------------------
package cqrk_pkg;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_REM = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam int ID_W     = 31;
    localparam int HANDLE_W = 16;
    localparam int ENTRY_W  = ID_W + HANDLE_W;

    typedef struct packed {
        logic [1:0]          operation;
        logic                queue_select;
        logic [ID_W-1:0]     report_id;
        logic [HANDLE_W-1:0] item_handle;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     out_report_id;
        logic [HANDLE_W-1:0] out_handle;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]     report_id;
        logic [HANDLE_W-1:0] item_handle;
    } t_entry;

endpackage

// ----- rtl/core/cqrk_ram.sv -----
// ----------------------------------------------------------------------------
// cqrk_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cqrk_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/circular_queue_remove_by_key_top.sv -----
// ----------------------------------------------------------------------------
// circular_queue_remove_by_key_top
// Two circular queues of (report ID, handle) entries with enqueue, dequeue
// and remove-by-ID, both queues kept in one RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// o_result with o_strobe high for exactly one cycle, and the receiver cannot
// stall it. Each queue holds up to QUEUE_SLOTS-1 entries. Enqueue and dequeue
// go from accept through the dispatch state to the result. Remove searches
// from the head, one entry per cycle, for the entry with the matching ID, then
// moves each entry behind it one slot toward the head to compact; a miss
// scans every entry of the queue. The single RAM read port, used once per
// cycle, sets this pace. A new item may start in the cycle its predecessor's
// result is shown.
module circular_queue_remove_by_key_top #(
    parameter int QUEUE_SLOTS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cqrk_pkg::t_in_item i_item,
    output logic               o_strobe,
    output cqrk_pkg::t_out_item o_result
);

    import cqrk_pkg::*;

    localparam int SW        = $clog2(QUEUE_SLOTS);
    localparam int AW        = SW + 1;
    localparam int RAM_DEPTH = 2 * (1 << SW);
    localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SHIFT
    } t_state;

    function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    t_state    r_state, n_state;
    logic [SW-1:0] r_lost_head, n_lost_head, r_lost_tail, n_lost_tail;
    logic [SW-1:0] r_found_head, n_found_head, r_found_tail, n_found_tail;
    logic [SW-1:0] r_cur, n_cur, r_rd, n_rd;
    t_in_item  r_item, n_item;
    logic      r_strobe, n_strobe;
    t_out_item r_result, n_result;

    logic [SW-1:0] sel_head, sel_tail, in_head;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    assign sel_head  = r_item.queue_select ? r_found_head : r_lost_head;
    assign sel_tail  = r_item.queue_select ? r_found_tail : r_lost_tail;
    assign in_head   = i_item.queue_select ? r_found_head : r_lost_head;
    assign ram_rdata = t_entry'(ram_rdata_raw);

    cqrk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ENTRY_W'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    always_comb begin
        n_state      = r_state;
        n_lost_head  = r_lost_head;
        n_lost_tail  = r_lost_tail;
        n_found_head = r_found_head;
        n_found_tail = r_found_tail;
        n_cur        = r_cur;
        n_rd         = r_rd;
        n_item       = r_item;
        n_strobe     = 1'b0;
        n_result     = r_result;
        ram_we       = 1'b0;
        ram_waddr    = {r_item.queue_select, r_cur};
        ram_wdata    = ram_rdata;
        ram_raddr    = {i_item.queue_select, in_head};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_result = '0;
                case (r_item.operation)
                    OP_ENQ: begin
                        if (slot_next(sel_tail) == sel_head) begin
                            n_result.status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = {r_item.queue_select, sel_tail};
                            ram_wdata = '{report_id: r_item.report_id,
                                          item_handle: r_item.item_handle};
                            if (r_item.queue_select) begin
                                n_found_tail = slot_next(sel_tail);
                            end else begin
                                n_lost_tail = slot_next(sel_tail);
                            end
                        end
                    end
                    OP_DEQ: begin
                        if (sel_head == sel_tail) begin
                            n_result.status = ST_EMPTY;
                        end else begin
                            n_result.out_report_id = ram_rdata.report_id;
                            n_result.out_handle    = ram_rdata.item_handle;
                            if (r_item.queue_select) begin
                                n_found_head = slot_next(sel_head);
                            end else begin
                                n_lost_head = slot_next(sel_head);
                            end
                        end
                    end
                    OP_REM: begin
                        if (sel_head == sel_tail) begin
                            n_result.status = ST_NOTFOUND;
                        end else begin
                            n_strobe  = 1'b0;
                            n_state   = S_SEARCH;
                            n_cur     = sel_head;
                            ram_raddr = {r_item.queue_select, sel_head};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SEARCH: begin
                ram_raddr = {r_item.queue_select, slot_next(r_cur)};
                if (ram_rdata.report_id == r_item.report_id) begin
                    if (slot_next(r_cur) == sel_tail) begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                        n_result = '0;
                        if (r_item.queue_select) begin
                            n_found_tail = slot_prev(sel_tail);
                        end else begin
                            n_lost_tail = slot_prev(sel_tail);
                        end
                    end else begin
                        n_state = S_SHIFT;
                        n_rd    = slot_next(r_cur);
                    end
                end else if (slot_next(r_cur) == sel_tail) begin
                    n_state         = S_IDLE;
                    n_strobe        = 1'b1;
                    n_result        = '0;
                    n_result.status = ST_NOTFOUND;
                end else begin
                    n_cur = slot_next(r_cur);
                end
            end
            S_SHIFT: begin
                // move entry one slot toward the head
                ram_we    = 1'b1;
                ram_waddr = {r_item.queue_select, r_cur};
                ram_wdata = ram_rdata;
                ram_raddr = {r_item.queue_select, slot_next(r_rd)};
                n_cur     = r_rd;
                n_rd      = slot_next(r_rd);
                if (slot_next(r_rd) == sel_tail) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_result = '0;
                    if (r_item.queue_select) begin
                        n_found_tail = slot_prev(sel_tail);
                    end else begin
                        n_lost_tail = slot_prev(sel_tail);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lost_head  <= '0;
            r_lost_tail  <= '0;
            r_found_head <= '0;
            r_found_tail <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_lost_head  <= n_lost_head;
            r_lost_tail  <= n_lost_tail;
            r_found_head <= n_found_head;
            r_found_tail <= n_found_tail;
            r_strobe     <= n_strobe;
        end
        r_cur    <= n_cur;
        r_rd     <= n_rd;
        r_item   <= n_item;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/core/cqrk_checker.sv -----
// ----------------------------------------------------------------------------
// cqrk_checker
// Port-level checks on the circular queue block, bound to its top level.
// ----------------------------------------------------------------------------
`include "circular_queue_remove_by_key_top_assert.svh"

module cqrk_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input cqrk_pkg::t_out_item o_result
);

    import cqrk_pkg::*;

    logic fail_shown;
    logic data_zero;

    assign fail_shown = o_strobe && (o_result.status != ST_OK);
    assign data_zero  = (o_result.out_report_id == '0) && (o_result.out_handle == '0);

    `CQRK_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
    `CQRK_ASSERT(a_strobe_idle, o_strobe |-> !busy, "result shown while still busy")
    `CQRK_ASSERT(a_strobe_after_work, o_strobe |-> $past(busy), "result without an item in work")
    `CQRK_ASSERT(a_zero_data, fail_shown |-> data_zero, "failed item carries data")
    `CQRK_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!o_strobe && !busy), "activity after reset")

endmodule

bind circular_queue_remove_by_key_top cqrk_checker u_cqrk_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
